FILE: rtl/usbin_pkg.sv
`default_nettype none

package usbin_pkg;

  // Default sizes of the packet store and of the overflow FIFO.
  localparam int PACKET_BYTES_DEF = 128;
  localparam int FIFO_DEPTH_DEF   = 512;

  // Largest packet size that the size register can select.
  localparam int SIZE_CAP = 128;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_FRAMES = 1'b1;
  localparam logic [7:0] PACKET_SIZE_RST  = 8'd128;
  localparam logic [7:0] FLUSH_FRAMES_RST = 8'd100;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Command codes, as carried on the input action field.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TAKE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e_t;

  // A classified command as presented by the front to the back.
  typedef struct packed {
    logic        valid;
    op_e_t       op;
    logic [7:0]  data;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/usbin_front.sv
`default_nettype none

module usbin_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [7:0]        in_byte_value,
  output usbin_pkg::cmd_t        cmd,
  input  wire logic              cmd_pop
);
  import usbin_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  op_e_t           q_op_r   [QUEUE_DEPTH];
  logic [7:0]      q_data_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;
  op_e_t           in_op;
  logic [7:0]      in_data;

  // Classify the incoming word: only a write carries its byte onward.
  always_comb begin
    in_op   = op_e_t'(in_action);
    in_data = (in_op == OP_WRITE) ? in_byte_value : 8'd0;
  end

  assign in_ready = (cnt_r != CNTW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = cmd_pop && (cnt_r != '0);

  // Pointer and occupancy update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_op_r[wr_ptr_r]   <= in_op;
      q_data_r[wr_ptr_r] <= in_data;
    end
  end

  always_comb begin
    cmd.valid = (cnt_r != '0);
    cmd.op    = q_op_r[rd_ptr_r];
    cmd.data  = q_data_r[rd_ptr_r];
  end

endmodule

`default_nettype wire

FILE: rtl/usbin_back.sv
`default_nettype none

module usbin_back #(
  parameter int PACKET_BYTES = usbin_pkg::PACKET_BYTES_DEF,
  parameter int FIFO_DEPTH   = usbin_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire usbin_pkg::cmd_t cmd,
  output logic              cmd_pop,
  input  wire logic [7:0]   packet_size,
  input  wire logic [7:0]   flush_frames,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_kind,
  output logic              out_accepted,
  output logic              out_armed_now,
  output logic [7:0]        out_packet_length,
  output logic [31:0]       out_data_word,
  output logic [2:0]        out_word_bytes,
  output logic              out_last
);
  import usbin_pkg::*;

  localparam int AW   = $clog2(PACKET_BYTES);
  localparam int FW   = $clog2(PACKET_BYTES + 1);
  localparam int QW   = $clog2(FIFO_DEPTH);
  localparam int CNW  = $clog2(FIFO_DEPTH + 1);
  localparam int CW   = (FW > 8) ? FW : 8;
  localparam int CAP  = (PACKET_BYTES < SIZE_CAP) ? PACKET_BYTES : SIZE_CAP;
  localparam logic [FW-1:0]  PB_F    = FW'(PACKET_BYTES);
  localparam logic [CNW-1:0] FD_C    = CNW'(FIFO_DEPTH);
  localparam logic [QW-1:0]  FD_LAST = QW'(FIFO_DEPTH - 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_REFILL_RD = 7'b0000010,
    S_REFILL_WR = 7'b0000100,
    S_STATUS    = 7'b0001000,
    S_RD        = 7'b0010000,
    S_CAP       = 7'b0100000,
    S_WORD      = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic            armed_r, armed_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [QW-1:0]   head_r, head_nxt;
  logic [QW-1:0]   tail_r, tail_nxt;
  logic [CNW-1:0]  count_r, count_nxt;
  logic [7:0]      frame_r, frame_nxt;
  logic            emit_r, emit_nxt;
  logic            acc_r, acc_nxt;
  logic [FW-1:0]   pos_r, pos_nxt;
  logic [2:0]      n_r, n_nxt;
  logic [31:0]     word_r, word_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic            out_acc_r, out_acc_nxt;
  logic            out_arm_r, out_arm_nxt;
  logic [7:0]      out_len_r, out_len_nxt;
  logic [31:0]     out_word_r, out_word_nxt;
  logic [2:0]      out_nb_r, out_nb_nxt;
  logic            out_last_r, out_last_nxt;

  logic [7:0]      store_mem [PACKET_BYTES];
  logic [7:0]      fifo_mem  [FIFO_DEPTH];
  logic [7:0]      store_q_r;
  logic [7:0]      fifo_q_r;
  logic            store_we;
  logic [7:0]      store_wdata;
  logic            fifo_we;

  logic [7:0]      eff_size;
  logic [7:0]      period;
  logic [7:0]      frame_inc;
  logic [FW-1:0]   fill_inc;
  logic [FW-1:0]   pos_inc;
  logic [2:0]      n_inc;
  logic            can_emit;
  logic            fill_lt_pb;

  // Effective packet size: zero acts as one, large values saturate.
  always_comb begin
    if (packet_size == 8'd0) begin
      eff_size = 8'd1;
    end else if (packet_size > 8'(CAP)) begin
      eff_size = 8'(CAP);
    end else begin
      eff_size = packet_size;
    end
    period = (flush_frames == 8'd0) ? 8'd1 : flush_frames;
  end

  assign can_emit   = !out_valid_r || out_ready;
  assign fill_inc   = fill_r + 1'b1;
  assign pos_inc    = pos_r + 1'b1;
  assign n_inc      = n_r + 3'd1;
  assign frame_inc  = frame_r + 8'd1;
  assign fill_lt_pb = (fill_r < PB_F);

  // Sequencer: one command at a time, status first, then packet words.
  always_comb begin
    state_nxt     = state_r;
    armed_nxt     = armed_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    frame_nxt     = frame_r;
    emit_nxt      = emit_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    word_nxt      = word_r;
    cmd_pop       = 1'b0;
    store_we      = 1'b0;
    store_wdata   = cmd.data;
    fifo_we       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_acc_nxt   = out_acc_r;
    out_arm_nxt   = out_arm_r;
    out_len_nxt   = out_len_r;
    out_word_nxt  = out_word_r;
    out_nb_nxt    = out_nb_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd.valid) begin
          cmd_pop   = 1'b1;
          emit_nxt  = 1'b0;
          acc_nxt   = 1'b0;
          state_nxt = S_STATUS;
          unique case (cmd.op)
            OP_WRITE: begin
              if (armed_r) begin
                // Packet waits for the host: the byte goes to the FIFO if it has room.
                if (count_r < FD_C) begin
                  fifo_we   = 1'b1;
                  tail_nxt  = (tail_r == FD_LAST) ? '0 : tail_r + 1'b1;
                  count_nxt = count_r + 1'b1;
                  acc_nxt   = 1'b1;
                end
              end else begin
                acc_nxt = 1'b1;
                if (fill_lt_pb) begin
                  store_we = 1'b1;
                  fill_nxt = fill_inc;
                end
                if (CW'(fill_lt_pb ? fill_inc : fill_r) >= CW'(eff_size)) begin
                  armed_nxt = 1'b1;
                  emit_nxt  = 1'b1;
                end
              end
            end
            OP_TAKE: begin
              if (armed_r) begin
                armed_nxt = 1'b0;
                fill_nxt  = '0;
                state_nxt = S_REFILL_RD;
              end
            end
            OP_TICK: begin
              if (frame_inc >= period) begin
                frame_nxt = 8'd0;
                if (!armed_r && (fill_r != '0)) begin
                  armed_nxt = 1'b1;
                  emit_nxt  = 1'b1;
                end
              end else begin
                frame_nxt = frame_inc;
              end
            end
            default: begin
              if (!armed_r && (fill_r != '0)) begin
                armed_nxt = 1'b1;
                emit_nxt  = 1'b1;
              end
            end
          endcase
        end
      end

      // Refill: read one FIFO byte, then write it into the store.
      S_REFILL_RD: begin
        if ((count_r != '0) && (CW'(fill_r) < CW'(eff_size))) begin
          head_nxt  = (head_r == FD_LAST) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = S_REFILL_WR;
        end else begin
          if (CW'(fill_r) == CW'(eff_size)) begin
            armed_nxt = 1'b1;
            emit_nxt  = 1'b1;
          end
          state_nxt = S_STATUS;
        end
      end

      S_REFILL_WR: begin
        store_we    = 1'b1;
        store_wdata = fifo_q_r;
        fill_nxt    = fill_inc;
        state_nxt   = S_REFILL_RD;
      end

      S_STATUS: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_acc_nxt   = acc_r;
          out_arm_nxt   = armed_r;
          out_len_nxt   = 8'(fill_r);
          out_word_nxt  = 32'd0;
          out_nb_nxt    = 3'd0;
          out_last_nxt  = !emit_r;
          pos_nxt       = '0;
          n_nxt         = 3'd0;
          word_nxt      = 32'd0;
          state_nxt     = emit_r ? S_RD : S_IDLE;
        end
      end

      // The store read is registered: address now, data next cycle.
      S_RD: begin
        state_nxt = S_CAP;
      end

      S_CAP: begin
        word_nxt[8*n_r[1:0] +: 8] = store_q_r;
        n_nxt   = n_inc;
        pos_nxt = pos_inc;
        if ((n_inc == 3'd4) || (pos_inc >= fill_r)) begin
          state_nxt = S_WORD;
        end else begin
          state_nxt = S_RD;
        end
      end

      S_WORD: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_acc_nxt   = 1'b0;
          out_arm_nxt   = 1'b1;
          out_len_nxt   = 8'(fill_r);
          out_word_nxt  = word_r;
          out_nb_nxt    = n_r;
          out_last_nxt  = (pos_r >= fill_r);
          n_nxt         = 3'd0;
          word_nxt      = 32'd0;
          state_nxt     = (pos_r >= fill_r) ? S_IDLE : S_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      fill_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      frame_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    emit_r     <= emit_nxt;
    acc_r      <= acc_nxt;
    pos_r      <= pos_nxt;
    n_r        <= n_nxt;
    word_r     <= word_nxt;
    out_kind_r <= out_kind_nxt;
    out_acc_r  <= out_acc_nxt;
    out_arm_r  <= out_arm_nxt;
    out_len_r  <= out_len_nxt;
    out_word_r <= out_word_nxt;
    out_nb_r   <= out_nb_nxt;
    out_last_r <= out_last_nxt;
  end

  // Packet store: written at the fill position, read at the emit position.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[fill_r[AW-1:0]] <= store_wdata;
    end
    store_q_r <= store_mem[pos_r[AW-1:0]];
  end

  // Overflow FIFO: written at the tail, read at the head.
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail_r] <= cmd.data;
    end
    fifo_q_r <= fifo_mem[head_r];
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_accepted      = out_acc_r;
  assign out_armed_now     = out_arm_r;
  assign out_packet_length = out_len_r;
  assign out_data_word     = out_word_r;
  assign out_word_bytes    = out_nb_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/usb_bulk_in_packet_assembler.sv
`default_nettype none

// Bulk IN packet assembler. Each input word is one action: write a byte,
// host took the packet, frame tick or flush. Every action yields one status
// word, followed by the packet's data words (up to four bytes each, first
// byte in the low bits) whenever a packet is armed by that action. A small
// command queue in front lets the input side keep writing while the
// sequencer works or the output is stalled. The sequencer handles one action
// at a time: each emitted byte is read through the single registered read
// port of the packet store before its data word is sent, and a host take
// moves the overflow FIFO into the packet store byte by byte, each byte read
// through the FIFO's single registered read port and then written. The user
// must keep to this: configuration is written only while idle; the block itself does not enforce it.
module usb_bulk_in_packet_assembler #(
  parameter int PACKET_BYTES = usbin_pkg::PACKET_BYTES_DEF,
  parameter int FIFO_DEPTH   = usbin_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_action,
  input  wire logic [7:0]                       in_byte_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic                                  out_accepted,
  output logic                                  out_armed_now,
  output logic [7:0]                            out_packet_length,
  output logic [31:0]                           out_data_word,
  output logic [2:0]                            out_word_bytes,
  output logic                                  out_last,
  input  wire logic                             cfg_we,
  input  wire logic [usbin_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                       cfg_wdata
);
  import usbin_pkg::*;

  logic [7:0] packet_size_r;
  logic [7:0] flush_frames_r;
  cmd_t       cmd;
  logic       cmd_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_size_r  <= PACKET_SIZE_RST;
      flush_frames_r <= FLUSH_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PACKET_SIZE:  packet_size_r  <= cfg_wdata;
        CFG_FLUSH_FRAMES: flush_frames_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  usbin_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  usbin_back #(
    .PACKET_BYTES (PACKET_BYTES),
    .FIFO_DEPTH   (FIFO_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .packet_size       (packet_size_r),
    .flush_frames      (flush_frames_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_accepted      (out_accepted),
    .out_armed_now     (out_armed_now),
    .out_packet_length (out_packet_length),
    .out_data_word     (out_data_word),
    .out_word_bytes    (out_word_bytes),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

FILE: test/tb_usb_bulk_in_packet_assembler.sv
`timescale 1ns / 1ps

module tb_usb_bulk_in_packet_assembler;
  import usbin_pkg::*;

  // One result word as it leaves the block, in port order.
  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic        armed_now;
    logic [7:0]  packet_length;
    logic [31:0] data_word;
    logic [2:0]  word_bytes;
    logic        last;
  } result_word_t;

  // Tracks the endpoint state and holds the result words still owed by the block.
  class packet_scoreboard;
    logic [7:0]   packet_size_reg;
    logic [7:0]   flush_frames_reg;
    bit           armed;
    int unsigned  fill;
    logic [7:0]   store [PACKET_BYTES_DEF];
    logic [7:0]   overflow [$];
    logic [7:0]   frame_count;
    result_word_t burst [$];
    result_word_t expected_words [$];
    int           errors;
    int           actions;
    int           words_checked;
    int           packets_armed;
    int           writes_refused;

    function new();
      packet_size_reg  = PACKET_SIZE_RST;
      flush_frames_reg = FLUSH_FRAMES_RST;
      armed            = 1'b0;
      fill             = 0;
      frame_count      = 8'd0;
      errors           = 0;
      actions          = 0;
      words_checked    = 0;
      packets_armed    = 0;
      writes_refused   = 0;
    endfunction

    // A size of zero behaves as one; large sizes are capped by the store.
    function int unsigned size_limit();
      int unsigned lim = packet_size_reg;
      if (lim == 0) lim = 1;
      if (lim > SIZE_CAP) lim = SIZE_CAP;
      if (lim > PACKET_BYTES_DEF) lim = PACKET_BYTES_DEF;
      return lim;
    endfunction

    // Arms the packet and queues its contents as data words of up to four bytes.
    function void arm_packet();
      result_word_t w;
      int unsigned  pos;
      armed = 1'b1;
      packets_armed++;
      pos = 0;
      while (pos < fill) begin
        w = '0;
        w.kind = 1'b1;
        w.armed_now = 1'b1;
        w.packet_length = 8'(fill);
        for (int n = 0; n < 4 && pos < fill; n++) begin
          w.data_word[8*n +: 8] = store[pos];
          w.word_bytes = 3'(n + 1);
          pos++;
        end
        w.last = (pos >= fill);
        burst.push_back(w);
      end
    endfunction

    // A flush only sends a partial packet that is not yet armed.
    function void flush_partial();
      if (!armed && fill > 0) arm_packet();
    endfunction

    // Works out the result words owed for one accepted action.
    function void note_action(op_e_t op, logic [7:0] value);
      result_word_t status;
      bit           took;
      int unsigned  lim;
      logic [7:0]   period;
      took = 1'b0;
      burst.delete();
      actions++;
      case (op)
        OP_WRITE: begin
          if (armed) begin
            if (overflow.size() < FIFO_DEPTH_DEF) begin
              overflow.push_back(value);
              took = 1'b1;
            end else begin
              writes_refused++;
            end
          end else begin
            if (fill < PACKET_BYTES_DEF) begin
              store[fill] = value;
              fill++;
            end
            took = 1'b1;
            if (fill >= size_limit()) arm_packet();
          end
        end
        OP_TAKE: begin
          // The host took the packet: refill from the overflow FIFO.
          if (armed) begin
            lim = size_limit();
            armed = 1'b0;
            fill = 0;
            while (overflow.size() != 0 && fill < lim) begin
              store[fill] = overflow.pop_front();
              fill++;
            end
            if (fill == lim) arm_packet();
          end
        end
        OP_TICK: begin
          period = (flush_frames_reg == 8'd0) ? 8'd1 : flush_frames_reg;
          frame_count++;
          if (frame_count >= period) begin
            frame_count = 8'd0;
            flush_partial();
          end
        end
        default: flush_partial();
      endcase
      status = '0;
      status.accepted = took;
      status.armed_now = armed;
      status.packet_length = 8'(fill);
      status.last = (burst.size() == 0);
      expected_words.push_back(status);
      foreach (burst[i]) expected_words.push_back(burst[i]);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    // Compares an accepted result word with the oldest one owed.
    function void check_result(result_word_t got);
      result_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, got %p", $time, got);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("armed_now", want.armed_now, got.armed_now);
      compare_field("packet_length", want.packet_length, got.packet_length);
      compare_field("data_word", want.data_word, got.data_word);
      compare_field("word_bytes", want.word_bytes, got.word_bytes);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_action = OP_WRITE;
  logic [7:0]           in_byte_value = 8'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_kind;
  logic                 out_accepted;
  logic                 out_armed_now;
  logic [7:0]           out_packet_length;
  logic [31:0]          out_data_word;
  logic [2:0]           out_word_bytes;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PACKET_SIZE;
  logic [7:0]           cfg_wdata = 8'd0;

  result_word_t     observed;
  packet_scoreboard sb;
  bit               no_idle = 1'b0;
  bit               long_hold_req = 1'b0;
  bit               long_hold_served = 1'b0;
  int               hold_left = 0;

  usb_bulk_in_packet_assembler uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_byte_value     (in_byte_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_accepted      (out_accepted),
    .out_armed_now     (out_armed_now),
    .out_packet_length (out_packet_length),
    .out_data_word     (out_data_word),
    .out_word_bytes    (out_word_bytes),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assign observed = {out_kind, out_accepted, out_armed_now, out_packet_length,
                     out_data_word, out_word_bytes, out_last};

  // Result side: check each accepted word, then choose the next ready level.
  // A requested long hold is counted down here, holding ready low meanwhile.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(observed);
    if (long_hold_req && !long_hold_served) begin
      long_hold_served = 1'b1;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 34);
    end
  end

  // Offers one action word, with random idle cycles in front of it, and
  // notes it once the block has taken it. Valid is left high on return.
  task automatic send_action(input op_e_t op, input logic [7:0] value);
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= op;
    in_byte_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_action(op, value);
  endtask

  // Mostly writes with random content, plus takes, ticks and flushes.
  task automatic send_random_actions(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_action(OP_WRITE, 8'($urandom));
      else if (pick < 72) send_action(OP_TAKE, 8'($urandom));
      else if (pick < 88) send_action(OP_TICK, 8'($urandom));
      else send_action(OP_FLUSH, 8'($urandom));
    end
  endtask

  // Stops offering and waits until every owed result word has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; only called while idle.
  task automatic configure(input logic [7:0] size, input logic [7:0] frames);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PACKET_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_index <= CFG_FLUSH_FRAMES;
    cfg_wdata <= frames;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.packet_size_reg  = size;
    sb.flush_frames_reg = frames;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle take, empty flush, a flushed partial packet,
    // bytes parked in the FIFO, flush while armed and a partial refill.
    send_action(OP_TAKE, 8'h00);
    send_action(OP_FLUSH, 8'hFF);
    send_action(OP_WRITE, 8'h00);
    send_action(OP_WRITE, 8'hFF);
    send_action(OP_WRITE, 8'hA5);
    send_action(OP_WRITE, 8'h5A);
    send_action(OP_FLUSH, 8'h00);
    send_action(OP_WRITE, 8'h01);
    send_action(OP_WRITE, 8'h80);
    send_action(OP_FLUSH, 8'h00);
    send_action(OP_TICK, 8'h00);
    send_action(OP_TAKE, 8'h00);
    send_action(OP_WRITE, 8'h7F);
    send_action(OP_WRITE, 8'h3C);
    send_action(OP_WRITE, 8'hC3);

    // Size shrunk below the current fill, and a zero flush period.
    settle();
    configure(8'd2, 8'd0);
    send_action(OP_WRITE, 8'h11);
    send_action(OP_TAKE, 8'h00);
    send_action(OP_TICK, 8'h00);
    send_action(OP_WRITE, 8'h22);
    send_action(OP_TICK, 8'h00);
    send_action(OP_TAKE, 8'h00);

    // A zero size acts as one byte; a refill of one byte arms at once.
    settle();
    configure(8'd0, 8'd255);
    send_action(OP_WRITE, 8'h33);
    send_action(OP_WRITE, 8'h44);
    send_action(OP_TAKE, 8'h00);
    send_action(OP_TAKE, 8'h00);

    // A full-size packet and bytes parked in the FIFO behind it, while the
    // result side holds off for a long stretch; a host take then refills.
    settle();
    configure(8'd128, 8'd100);
    long_hold_req = 1'b1;
    repeat (128) send_action(OP_WRITE, 8'($urandom));
    repeat (24) send_action(OP_WRITE, 8'($urandom));
    send_action(OP_TAKE, 8'($urandom));

    // Random phases, each under its own settings; one runs without idling.
    for (int p = 0; p < 5; p++) begin
      settle();
      no_idle = (p == 1);
      case (p)
        0: configure(8'($urandom_range(2, 12)), 8'($urandom_range(2, 6)));
        1: configure(8'd4, 8'd1);
        2: configure(8'd1, 8'd255);
        3: configure(8'd255, 8'd3);
        default: configure(8'($urandom_range(13, 40)), 8'($urandom_range(1, 10)));
      endcase
      send_random_actions(36);
    end

    settle();
    no_idle = 1'b0;
    repeat (40) @(posedge clk);
    $display("Sent %0d actions and checked %0d result words.", sb.actions, sb.words_checked);
    $display("Packets armed: %0d; writes refused by a full FIFO: %0d.",
             sb.packets_armed, sb.writes_refused);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
